/* hdl/logic_gate_network_update_defines.svh */
// Assertion macros shared by the gate network RTL.
`ifndef LOGIC_GATE_NETWORK_UPDATE_DEFINES_SVH
`define LOGIC_GATE_NETWORK_UPDATE_DEFINES_SVH

// Invariant checked at every clock edge outside reset.
`define LGN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define LGN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LGN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/lgn_pkg.sv */
// Types, codes and helper functions for the logic gate network.
package lgn_pkg;

  localparam int unsigned NODE_W    = 64;
  localparam int unsigned MAX_NODES = 64;

  typedef enum logic [2:0] {
    KIND_CLEAR_ALL   = 3'd0,
    KIND_APPEND      = 3'd1,
    KIND_SENSE       = 3'd2,
    KIND_TICK        = 3'd3,
    KIND_CLEAR_NODES = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_WIRE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_SENSOR   = 2'd0,
    CFG_ACTUATOR = 2'd1,
    CFG_HIDDEN   = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_HOLD
  } state_e;

  // One stored gate; arities kept as count minus one.
  typedef struct packed {
    logic [1:0]  in_m1;
    logic [23:0] in_wires;
    logic [1:0]  out_m1;
    logic [23:0] out_wires;
    logic [15:0] logic_table;
  } gate_t;

  // Evaluator control for one cycle of a tick.
  typedef struct packed {
    logic clear;
    logic run;
    logic use_gate;
  } eval_ctrl_t;

  function automatic logic [NODE_W-1:0] low_mask(input logic [6:0] n);
    if (n >= 7'(NODE_W)) begin
      return '1;
    end
    return (NODE_W'(1) << n[5:0]) - NODE_W'(1);
  endfunction

  function automatic logic [1:0] arity_m1(input logic [2:0] a);
    if (a == 3'd0) begin
      return 2'd0;
    end
    if (a > 3'd4) begin
      return 2'd3;
    end
    return 2'(a - 3'd1);
  endfunction

  function automatic logic wires_ok(input logic [1:0] m1, input logic [23:0] w,
                                    input logic [6:0] total);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (k <= int'(m1) && {1'b0, w[6*k +: 6]} >= total) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

/* hdl/lgn_cell.sv */
// One gate-record cell of the rotating gate ring.
module lgn_cell (
  input  logic           clk_i,
  input  logic           load_en_i,
  input  logic           shift_en_i,
  input  lgn_pkg::gate_t load_rec_i,
  input  lgn_pkg::gate_t next_rec_i,
  output lgn_pkg::gate_t rec_o
);

  lgn_pkg::gate_t rec_q;
  lgn_pkg::gate_t rec_d;

  always_comb begin
    rec_d = rec_q;
    if (load_en_i) begin
      rec_d = load_rec_i;
    end else if (shift_en_i) begin
      rec_d = next_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule

/* hdl/lgn_eval.sv */
// Head-of-ring gate evaluator and next-node accumulator.
module lgn_eval (
  input  logic                       clk_i,
  input  lgn_pkg::eval_ctrl_t        ctrl_i,
  input  lgn_pkg::gate_t             rec_i,
  input  logic [lgn_pkg::NODE_W-1:0] cur_i,
  output logic [lgn_pkg::NODE_W-1:0] acc_o
);

  logic [lgn_pkg::NODE_W-1:0] acc_q;
  logic [lgn_pkg::NODE_W-1:0] acc_d;
  logic [lgn_pkg::NODE_W-1:0] out_mask;
  logic [lgn_pkg::NODE_W-1:0] contrib;
  logic [3:0]                 in_bits;
  logic [3:0]                 idx;
  logic                       fire;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      in_bits[k] = cur_i[rec_i.in_wires[6*k +: 6]];
    end
    case (rec_i.in_m1)
      2'd0:    idx = {3'b000, in_bits[0]};
      2'd1:    idx = {2'b00, in_bits[0], in_bits[1]};
      2'd2:    idx = {1'b0, in_bits[0], in_bits[1], in_bits[2]};
      default: idx = {in_bits[0], in_bits[1], in_bits[2], in_bits[3]};
    endcase
    fire = rec_i.logic_table[idx];
    out_mask = '0;
    for (int k = 0; k < 4; k++) begin
      if (k <= int'(rec_i.out_m1)) begin
        out_mask[rec_i.out_wires[6*k +: 6]] = 1'b1;
      end
    end
    contrib = (ctrl_i.run && ctrl_i.use_gate && fire) ? out_mask : '0;
  end

  assign acc_o = acc_q | contrib;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.run) begin
      acc_d = acc_o;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

/* hdl/logic_gate_network_update.sv */
// Logic gate network top level: gate ring, node vector, control and result register.
// Gates live in a ring of MAX_GATES cells; a tick rotates the ring one cell per cycle
// past a single evaluator at its head, then passes through a hold state that loads the
// result register once the output is free.
// Every other request (clear, append, sensor load, node clear) goes from accept through
// the same hold state into the result register.
// One request is in flight at a time; a new request is taken once the previous
// result is in the output register, even while that result is still stalled.
// No clearing pass is needed after reset.
`include "logic_gate_network_update_defines.svh"

module logic_gate_network_update #(
  parameter int unsigned MAX_GATES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [2:0]  input_arity_i,
  input  logic [23:0] input_wires_i,
  input  logic [2:0]  output_arity_i,
  input  logic [23:0] output_wires_i,
  input  logic [15:0] logic_table_i,
  input  logic [63:0] sense_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [63:0] actuator_bits_o
);

  localparam int unsigned CNT_W = $clog2(MAX_GATES + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAX_GATES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(MAX_GATES);

  lgn_pkg::state_e state_q, state_d;
  logic [6:0]       sensor_q, actuator_q, hidden_q;
  logic [63:0]      node_q, node_d;
  logic [CNT_W-1:0] gate_cnt_q, gate_cnt_d;
  logic [CNT_W-1:0] step_q, step_d;
  logic [1:0]       hold_status_q, hold_status_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [63:0]      act_q, act_d;

  logic [8:0]  node_sum;
  logic [6:0]  total;
  logic [63:0] total_mask;
  logic [63:0] live;
  logic [6:0]  sens_n;
  logic [7:0]  sa_sum;
  logic [6:0]  act_end;
  logic [63:0] view;
  logic [63:0] sens_mask;
  logic        in_acc;
  logic        out_free;
  logic        table_full;
  logic        wires_good;
  logic        append_ok;
  lgn_pkg::kind_e      kind;
  lgn_pkg::gate_t      new_rec;
  lgn_pkg::eval_ctrl_t ectrl;
  logic [63:0]         acc;
  lgn_pkg::gate_t      ring [MAX_GATES];

  assign kind       = lgn_pkg::kind_e'(kind_i);
  assign in_stall_o = (state_q != lgn_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Node bookkeeping
  always_comb begin
    node_sum   = 9'(sensor_q) + 9'(actuator_q) + 9'(hidden_q);
    total      = (node_sum > 9'(lgn_pkg::MAX_NODES)) ? 7'(lgn_pkg::MAX_NODES)
                                                      : node_sum[6:0];
    total_mask = lgn_pkg::low_mask(total);
    live       = node_q & total_mask;
    sens_n     = (sensor_q < total) ? sensor_q : total;
    sa_sum     = 8'(sensor_q) + 8'(actuator_q);
    act_end    = (sa_sum > 8'(total)) ? total : sa_sum[6:0];
    sens_mask  = lgn_pkg::low_mask(sens_n);
    if (sens_n >= 7'(lgn_pkg::NODE_W)) begin
      view = '0;
    end else begin
      view = (live >> sens_n[5:0]) & lgn_pkg::low_mask(7'(act_end - sens_n));
    end
  end

  // Append checks
  always_comb begin
    new_rec.in_m1       = lgn_pkg::arity_m1(input_arity_i);
    new_rec.in_wires    = input_wires_i;
    new_rec.out_m1      = lgn_pkg::arity_m1(output_arity_i);
    new_rec.out_wires   = output_wires_i;
    new_rec.logic_table = logic_table_i;
    table_full = (gate_cnt_q >= FULL_CNT);
    wires_good = lgn_pkg::wires_ok(new_rec.in_m1, input_wires_i, total) &&
                 lgn_pkg::wires_ok(new_rec.out_m1, output_wires_i, total);
    append_ok  = in_acc && (kind == lgn_pkg::KIND_APPEND) && !table_full && wires_good;
  end

  // Gate ring
  for (genvar i = 0; i < MAX_GATES; i++) begin : g_ring
    lgn_cell u_cell (
      .clk_i      (clk_i),
      .load_en_i  (append_ok && (gate_cnt_q == CNT_W'(i))),
      .shift_en_i (state_q == lgn_pkg::S_TICK),
      .load_rec_i (new_rec),
      .next_rec_i (ring[(i + 1) % MAX_GATES]),
      .rec_o      (ring[i])
    );
  end

  assign ectrl = '{clear:    in_acc && (kind == lgn_pkg::KIND_TICK),
                   run:      (state_q == lgn_pkg::S_TICK),
                   use_gate: (step_q < gate_cnt_q)};

  lgn_eval u_eval (
    .clk_i  (clk_i),
    .ctrl_i (ectrl),
    .rec_i  (ring[0]),
    .cur_i  (live),
    .acc_o  (acc)
  );

  // Control
  always_comb begin
    state_d       = state_q;
    node_d        = node_q;
    gate_cnt_d    = gate_cnt_q;
    step_d        = step_q;
    hold_status_d = hold_status_q;
    out_valid_d   = out_valid_q;
    status_d      = status_q;
    act_d         = act_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      lgn_pkg::S_IDLE: begin
        if (in_acc) begin
          hold_status_d = lgn_pkg::STATUS_OK;
          state_d       = lgn_pkg::S_HOLD;
          case (kind)
            lgn_pkg::KIND_CLEAR_ALL: begin
              gate_cnt_d = '0;
              node_d     = '0;
            end
            lgn_pkg::KIND_APPEND: begin
              if (table_full) begin
                hold_status_d = lgn_pkg::STATUS_FULL;
              end else if (!wires_good) begin
                hold_status_d = lgn_pkg::STATUS_BAD_WIRE;
              end else begin
                gate_cnt_d = gate_cnt_q + CNT_W'(1);
              end
            end
            lgn_pkg::KIND_SENSE: begin
              node_d = (live & ~sens_mask) | (sense_bits_i & sens_mask);
            end
            lgn_pkg::KIND_TICK: begin
              step_d  = '0;
              state_d = lgn_pkg::S_TICK;
            end
            lgn_pkg::KIND_CLEAR_NODES: begin
              node_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      lgn_pkg::S_TICK: begin
        step_d = step_q + CNT_W'(1);
        if (step_q == LAST_STEP) begin
          node_d  = acc & total_mask;
          state_d = lgn_pkg::S_HOLD;
        end
      end
      lgn_pkg::S_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = hold_status_q;
          act_d       = view;
          state_d     = lgn_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = lgn_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= lgn_pkg::S_IDLE;
      node_q        <= '0;
      gate_cnt_q    <= '0;
      step_q        <= '0;
      hold_status_q <= lgn_pkg::STATUS_OK;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      node_q        <= node_d;
      gate_cnt_q    <= gate_cnt_d;
      step_q        <= step_d;
      hold_status_q <= hold_status_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    act_q    <= act_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_q   <= 7'd8;
      actuator_q <= 7'd4;
      hidden_q   <= 7'd8;
    end else if (cfg_we_i) begin
      case (lgn_pkg::cfg_e'(cfg_idx_i))
        lgn_pkg::CFG_SENSOR:   sensor_q   <= cfg_data_i;
        lgn_pkg::CFG_ACTUATOR: actuator_q <= cfg_data_i;
        lgn_pkg::CFG_HIDDEN:   hidden_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign actuator_bits_o = act_q;

  `LGN_ASSERT_ALWAYS(a_cnt_bound, gate_cnt_q <= FULL_CNT, "gate count beyond table size")
  `LGN_ASSERT_NEXT(a_full_holds,
    in_acc && kind == lgn_pkg::KIND_APPEND && table_full,
    $stable(gate_cnt_q), "append stored into a full table")
  `LGN_ASSERT_NEXT(a_clear_cnt, in_acc && kind == lgn_pkg::KIND_CLEAR_ALL,
    gate_cnt_q == '0, "gate table not cleared")
  `LGN_ASSERT_NEXT(a_step_adv, state_q == lgn_pkg::S_TICK && step_q != LAST_STEP,
    state_q == lgn_pkg::S_TICK && step_q == $past(step_q) + CNT_W'(1),
    "tick ended early or step skipped")
  `LGN_ASSERT_IMPL(a_tick_mask,
    state_q == lgn_pkg::S_HOLD && $past(state_q) == lgn_pkg::S_TICK,
    (node_q & ~total_mask) == '0, "tick set a node beyond node total")

endmodule

/* tb/logic_gate_network_update_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the logic gate network update block.
module logic_gate_network_update_tb;

  localparam int unsigned GATE_SLOTS   = 256;
  localparam int unsigned ITEM_BUDGET  = 2200;
  localparam int unsigned CYCLE_LIMIT  = ITEM_BUDGET * 300 * 4;
  localparam int unsigned DRAIN_CYCLES = GATE_SLOTS + 40;
  localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  in_arity;
    logic [23:0] in_wires;
    logic [2:0]  out_arity;
    logic [23:0] out_wires;
    logic [15:0] lut;
    logic [63:0] sense;
  } request_t;

  typedef struct packed {
    lgn_pkg::status_e status;
    logic [63:0]      act;
  } readout_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_idx_i       = '0;
  logic [6:0]  cfg_data_i      = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i          = '0;
  logic [2:0]  input_arity_i   = '0;
  logic [23:0] input_wires_i   = '0;
  logic [2:0]  output_arity_i  = '0;
  logic [23:0] output_wires_i  = '0;
  logic [15:0] logic_table_i   = '0;
  logic [63:0] sense_bits_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [1:0]  status_o;
  logic [63:0] actuator_bits_o;

  // Network state as the block should hold it.
  logic [6:0]  sensor_cnt   = 7'd8;
  logic [6:0]  actuator_cnt = 7'd4;
  logic [6:0]  hidden_cnt   = 7'd8;
  logic [63:0] nodes        = '0;
  int          gate_cnt     = 0;
  int          gate_in_n    [GATE_SLOTS];
  int          gate_out_n   [GATE_SLOTS];
  logic [23:0] gate_in_w    [GATE_SLOTS];
  logic [23:0] gate_out_w   [GATE_SLOTS];
  logic [15:0] gate_lut     [GATE_SLOTS];

  readout_t    readout_q[$];
  int          mismatches = 0;
  int          burst_left = 0;
  int unsigned cycle_cnt  = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic [7:0]  stall_phase = '0;

  logic_gate_network_update #(
    .MAX_GATES(GATE_SLOTS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .input_arity_i  (input_arity_i),
    .input_wires_i  (input_wires_i),
    .output_arity_i (output_arity_i),
    .output_wires_i (output_wires_i),
    .logic_table_i  (logic_table_i),
    .sense_bits_i   (sense_bits_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .actuator_bits_o(actuator_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] span_mask(input int n);
    if (n >= 64) begin
      return '1;
    end
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic int node_span();
    int t;
    t = sensor_cnt + actuator_cnt + hidden_cnt;
    return (t > 64) ? 64 : t;
  endfunction

  function automatic int clamp_count(input logic [2:0] a);
    if (a == 3'd0) begin
      return 1;
    end
    return (a > 3'd4) ? 4 : int'(a);
  endfunction

  function automatic bit wires_fit(input int n, input logic [23:0] w, input int total);
    for (int k = 0; k < n; k++) begin
      if (int'(w[6*k +: 6]) >= total) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [23:0] wires4(input logic [5:0] a, input logic [5:0] b,
                                         input logic [5:0] c, input logic [5:0] d);
    return {d, c, b, a};
  endfunction

  function automatic logic [23:0] random_wires(input int total);
    logic [23:0] w;
    for (int k = 0; k < 4; k++) begin
      w[6*k +: 6] = 6'($urandom_range(0, total - 1));
    end
    return w;
  endfunction

  function automatic logic [63:0] actuator_view();
    int          total;
    int          lo;
    int          hi;
    logic [63:0] live;
    total = node_span();
    lo    = (sensor_cnt < total) ? int'(sensor_cnt) : total;
    hi    = sensor_cnt + actuator_cnt;
    if (hi > total) begin
      hi = total;
    end
    live = nodes & span_mask(total);
    if (lo >= 64) begin
      return '0;
    end
    return (live >> lo) & span_mask(hi - lo);
  endfunction

  // Applies one request to the network state and returns the readout it yields.
  function automatic readout_t network_step(input request_t r);
    readout_t    res;
    int          total;
    int          na;
    int          nb;
    logic [63:0] cur;
    logic [63:0] nxt;
    logic [63:0] m;
    logic [3:0]  idx;
    res.status = lgn_pkg::STATUS_OK;
    total      = node_span();
    case (r.kind)
      lgn_pkg::KIND_CLEAR_ALL: begin
        gate_cnt = 0;
        nodes    = '0;
      end
      lgn_pkg::KIND_APPEND: begin
        na = clamp_count(r.in_arity);
        nb = clamp_count(r.out_arity);
        if (gate_cnt >= GATE_SLOTS) begin
          res.status = lgn_pkg::STATUS_FULL;
        end else if (!wires_fit(na, r.in_wires, total) ||
                     !wires_fit(nb, r.out_wires, total)) begin
          res.status = lgn_pkg::STATUS_BAD_WIRE;
        end else begin
          gate_in_n[gate_cnt]  = na;
          gate_out_n[gate_cnt] = nb;
          gate_in_w[gate_cnt]  = r.in_wires;
          gate_out_w[gate_cnt] = r.out_wires;
          gate_lut[gate_cnt]   = r.lut;
          gate_cnt++;
        end
      end
      lgn_pkg::KIND_SENSE: begin
        m     = span_mask((sensor_cnt < total) ? int'(sensor_cnt) : total);
        nodes = (nodes & span_mask(total) & ~m) | (r.sense & m);
      end
      lgn_pkg::KIND_TICK: begin
        cur = nodes & span_mask(total);
        nxt = '0;
        for (int g = 0; g < gate_cnt; g++) begin
          idx = '0;
          for (int k = 0; k < gate_in_n[g]; k++) begin
            idx = {idx[2:0], cur[gate_in_w[g][6*k +: 6]]};
          end
          if (gate_lut[g][idx]) begin
            for (int k = 0; k < gate_out_n[g]; k++) begin
              nxt[gate_out_w[g][6*k +: 6]] = 1'b1;
            end
          end
        end
        nodes = nxt & span_mask(total);
      end
      lgn_pkg::KIND_CLEAR_NODES: begin
        nodes = '0;
      end
      default: begin
      end
    endcase
    res.act = actuator_view();
    return res;
  endfunction

  task automatic send_request(input logic [2:0] kind, input logic [2:0] in_ar,
                              input logic [23:0] in_w, input logic [2:0] out_ar,
                              input logic [23:0] out_w, input logic [15:0] lut,
                              input logic [63:0] sense);
    request_t r;
    readout_t want;
    r = '{kind, in_ar, in_w, out_ar, out_w, lut, sense};
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat (($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 20))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
    end
    burst_left--;
    kind_i         <= r.kind;
    input_arity_i  <= r.in_arity;
    input_wires_i  <= r.in_wires;
    output_arity_i <= r.out_arity;
    output_wires_i <= r.out_wires;
    logic_table_i  <= r.lut;
    sense_bits_i   <= r.sense;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    want      = network_step(r);
    readout_q = {readout_q, want};
  endtask

  // Holds off requests until every readout is back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_layout(input logic [6:0] s, input logic [6:0] a, input logic [6:0] h);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= lgn_pkg::CFG_SENSOR;
    cfg_data_i <= s;
    @(posedge clk_i);
    sensor_cnt = s;
    cfg_idx_i  <= lgn_pkg::CFG_ACTUATOR;
    cfg_data_i <= a;
    @(posedge clk_i);
    actuator_cnt = a;
    cfg_idx_i  <= lgn_pkg::CFG_HIDDEN;
    cfg_data_i <= h;
    @(posedge clk_i);
    hidden_cnt = h;
    cfg_we_i   <= 1'b0;
  endtask

  // Random mix of request kinds; appends are mostly well-formed with all four slots in range; some raw noise.
  task automatic send_random_request();
    int          roll;
    int          total;
    logic [2:0]  kind;
    logic [2:0]  in_ar;
    logic [2:0]  out_ar;
    logic [23:0] in_w;
    logic [23:0] out_w;
    roll   = $urandom_range(0, 99);
    total  = node_span();
    in_ar  = 3'($urandom_range(0, 7));
    out_ar = 3'($urandom_range(0, 7));
    in_w   = 24'($urandom);
    out_w  = 24'($urandom);
    if (roll < 34) begin
      kind = lgn_pkg::KIND_APPEND;
      if (roll >= 6 && total > 0) begin
        in_w  = random_wires(total);
        out_w = random_wires(total);
      end
    end else if (roll < 54) begin
      kind = lgn_pkg::KIND_SENSE;
    end else if (roll < 86) begin
      kind = lgn_pkg::KIND_TICK;
    end else if (roll < 92) begin
      kind = lgn_pkg::KIND_CLEAR_NODES;
    end else if (roll < 94) begin
      kind = lgn_pkg::KIND_CLEAR_ALL;
    end else begin
      kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    end
    send_request(kind, in_ar, in_w, out_ar, out_w, 16'($urandom), {$urandom, $urandom});
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      send_random_request();
    end
  endtask

  // Reset layout: sensors 0-7, actuators 8-11, hidden 12-19.
  task automatic test_directed();
    send_request(lgn_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
    send_request(lgn_pkg::KIND_SENSE, '1, '1, '1, '1, '1, '1);
    send_request(lgn_pkg::KIND_APPEND, 3'd1, wires4(0, 0, 0, 0), 3'd4, wires4(8, 9, 10, 11),
                 16'h0002, '0);
    send_request(lgn_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
    send_request(lgn_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
    // unused slots out of range must be ignored
    send_request(lgn_pkg::KIND_APPEND, 3'd0, wires4(19, 63, 63, 63), 3'd1,
                 wires4(19, 63, 63, 63), 16'h0001, '0);
    send_request(lgn_pkg::KIND_APPEND, 3'd7, wires4(0, 1, 2, 3), 3'd7, wires4(8, 10, 12, 19),
                 16'h8000, '0);
    send_request(lgn_pkg::KIND_APPEND, 3'd2, wires4(5, 20, 0, 0), 3'd1, wires4(9, 0, 0, 0),
                 '1, '0);
    send_request(lgn_pkg::KIND_APPEND, 3'd1, wires4(5, 0, 0, 0), 3'd2, wires4(9, 63, 0, 0),
                 '1, '0);
    send_request(lgn_pkg::KIND_APPEND, 3'd4, wires4(19, 12, 8, 0), 3'd1, wires4(11, 0, 0, 0),
                 16'hFFFF, '0);
    send_request(lgn_pkg::KIND_APPEND, 3'd4, wires4(19, 12, 8, 0), 3'd1, wires4(9, 0, 0, 0),
                 16'h0000, '0);
    send_request(lgn_pkg::KIND_SENSE, '0, '0, '0, '0, '0, 64'hF);
    send_request(lgn_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
    send_request(lgn_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
    send_request(lgn_pkg::KIND_SENSE, '0, '0, '0, '0, '0, '1);
    send_request(lgn_pkg::KIND_TICK, '1, '1, '1, '1, '1, '1);
    send_request(lgn_pkg::KIND_CLEAR_NODES, '1, '1, '1, '1, '1, '1);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_request(3'(k), '1, '1, '1, '1, '1, '1);
    end
    send_request(lgn_pkg::KIND_SENSE, '1, '1, '1, '1, '1, '0);
    send_request(lgn_pkg::KIND_CLEAR_ALL, '1, '1, '1, '1, '1, '1);
    send_request(lgn_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_table_full();
    set_layout(7'd16, 7'd16, 7'd16);
    send_request(lgn_pkg::KIND_CLEAR_ALL, '0, '0, '0, '0, '0, '0);
    for (int g = 0; g < GATE_SLOTS; g++) begin
      send_request(lgn_pkg::KIND_APPEND, 3'($urandom_range(1, 4)), random_wires(48),
                   3'($urandom_range(1, 4)), random_wires(48), 16'($urandom), '0);
    end
    send_request(lgn_pkg::KIND_APPEND, 3'd1, '0, 3'd1, '0, 16'hFFFF, '0);
    // full takes precedence over a bad wire
    send_request(lgn_pkg::KIND_APPEND, 3'd4, '1, 3'd4, '1, 16'hFFFF, '0);
    send_request(lgn_pkg::KIND_SENSE, '0, '0, '0, '0, '0, {$urandom, $urandom});
    repeat (3) send_request(lgn_pkg::KIND_TICK, '0, '0, '0, '0, '0, '0);
    send_request(lgn_pkg::KIND_CLEAR_ALL, '0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_layout_sweep();
    set_layout(7'd0, 7'd0, 7'd0);
    run_random(30);
    set_layout(7'd64, 7'd64, 7'd64);
    run_random(40);
    set_layout(7'd0, 7'd64, 7'd0);
    run_random(40);
    set_layout(7'd64, 7'd0, 7'd0);
    run_random(30);
    set_layout(7'd0, 7'd0, 7'd64);
    run_random(30);
    set_layout(7'd1, 7'd1, 7'd1);
    run_random(30);
    set_layout(7'd40, 7'd30, 7'd20);
    run_random(40);
    set_layout(7'd8, 7'd4, 7'd8);
    run_random(30);
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      if ($urandom_range(0, 1) == 0) begin
        set_layout(7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)),
                   7'($urandom_range(0, 64)));
      end else begin
        set_layout(7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)),
                   7'($urandom_range(0, 12)));
      end
      run_random(160);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= STALL_NONE;
      stall_phase <= '0;
    end else begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase == 8'hFF) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
        default:     out_stall_i <= ((stall_phase % 5) < 3);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_readout
    readout_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (readout_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: status %0d actuators %h", $time, status_o,
                 actuator_bits_o);
      end else begin
        want = readout_q.pop_front();
        if (status_o !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
        end
        if (actuator_bits_o !== want.act) begin
          mismatches++;
          $display("%0t: actuators expected %h actual %h", $time, want.act, actuator_bits_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_layout_sweep();
    test_random();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && readout_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
